@@ design/brb_pkg.sv @@
`timescale 1ns / 1ps
package brb_pkg;

  localparam int RING_DEPTH_DEF = 128;
  localparam int PACKET_MAX_DEF = 64;
  localparam int HEADER_BYTES   = 4;
  localparam int RESULT_LIMIT   = 64;

  // command codes on the input
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_PACKET = 2'd1;
  localparam logic [1:0] CMD_COUNT  = 2'd2;

  // classified operations held in the queue
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_COUNT  = 2'd2;
  localparam logic [1:0] OP_REJECT = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [6:0] cnt;
  } brb_entry_t;

endpackage

@@ design/brb_front.sv @@
`timescale 1ns / 1ps
module brb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_in,
  input  logic [6:0]         read_count,
  output logic               head_valid,
  output brb_pkg::brb_entry_t head,
  input  logic               pop
);
  import brb_pkg::*;

  brb_entry_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       push;
  brb_entry_t entry;

  // classify: count checks that need no buffer state are settled here
  always_comb begin
    entry.data = data_in;
    entry.cnt  = read_count;
    case (cmd)
      CMD_WRITE:  entry.op = OP_WRITE;
      CMD_PACKET: entry.op = OP_PACKET;
      CMD_COUNT: begin
        if (read_count == 7'd0 || 32'(read_count) > RESULT_LIMIT) begin
          entry.op = OP_REJECT;
        end else begin
          entry.op = OP_COUNT;
        end
      end
      default:    entry.op = OP_REJECT;
    endcase
  end

  assign busy       = (count == 2'd2);
  assign accept     = start && !busy;
  // unused command code makes no entry
  assign push       = accept && (cmd == CMD_WRITE || cmd == CMD_PACKET || cmd == CMD_COUNT);
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ design/brb_back.sv @@
`timescale 1ns / 1ps
module brb_back #(
  parameter int RING_DEPTH = brb_pkg::RING_DEPTH_DEF,
  parameter int PACKET_MAX = brb_pkg::PACKET_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  brb_pkg::brb_entry_t head,
  output logic               pop,
  output logic               strobe,
  output logic [7:0]         data_out,
  output logic               last,
  output logic [1:0]         status,
  output logic [7:0]         stored_count
);
  import brb_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HDR   = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [7:0]    mem [RING_DEPTH];
  logic [7:0]    mem_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [1:0]    state;
  logic [AW-1:0] rptr;
  logic [AW-1:0] wptr;
  logic [AW-1:0] hptr;
  logic [FW-1:0] fill;
  logic [2:0]    hcnt;
  logic [7:0]    len_lo;
  logic          len_hi_nz;
  logic [6:0]    remaining;
  logic          full;

  logic          st_valid;
  logic [1:0]    st_code;
  logic [FW-1:0] st_fill;
  logic          rd_pend;
  logic          rd_last;
  logic [FW-1:0] rd_fill;
  logic [FW+7:0] st_fill_x;
  logic [FW+7:0] rd_fill_x;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign full    = (fill == FW'(RING_DEPTH));
  assign pop     = (state == S_IDLE) && head_valid;
  assign mem_we  = pop && (head.op == OP_WRITE) && !full;
  assign rd_addr = (state == S_HDR) ? hptr : rptr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr] <= head.data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rptr     <= '0;
      wptr     <= '0;
      fill     <= '0;
      st_valid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      st_valid <= 1'b0;
      rd_pend  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_WRITE: begin
                st_valid <= 1'b1;
                if (full) begin
                  st_code <= ST_FULL;
                  st_fill <= fill;
                end else begin
                  wptr    <= ptr_inc(wptr);
                  fill    <= fill + FW'(1);
                  st_code <= ST_OK;
                  st_fill <= fill + FW'(1);
                end
              end
              OP_COUNT: begin
                if (32'(head.cnt) > 32'(fill)) begin
                  st_valid <= 1'b1;
                  st_code  <= ST_SHORT;
                  st_fill  <= fill;
                end else begin
                  remaining <= head.cnt;
                  state     <= S_DRAIN;
                end
              end
              OP_PACKET: begin
                if (32'(fill) < HEADER_BYTES) begin
                  st_valid <= 1'b1;
                  st_code  <= ST_SHORT;
                  st_fill  <= fill;
                end else begin
                  hptr      <= rptr;
                  hcnt      <= 3'd0;
                  len_hi_nz <= 1'b0;
                  state     <= S_HDR;
                end
              end
              default: begin
                st_valid <= 1'b1;
                st_code  <= ST_SHORT;
                st_fill  <= fill;
              end
            endcase
          end
        end
        S_HDR: begin
          // header reads go out on counts 0..3; the registered read data is taken on counts 1..4
          hptr <= ptr_inc(hptr);
          hcnt <= hcnt + 3'd1;
          if (hcnt == 3'd1) begin
            len_lo <= mem_q;
          end else if (hcnt != 3'd0) begin
            len_hi_nz <= len_hi_nz | (|mem_q);
          end
          if (hcnt == 3'd4) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (len_hi_nz || 32'(len_lo) < HEADER_BYTES || 32'(len_lo) > PACKET_MAX) begin
            st_valid <= 1'b1;
            st_code  <= ST_BADLEN;
            st_fill  <= fill;
            state    <= S_IDLE;
          end else if (32'(len_lo) > 32'(fill)) begin
            st_valid <= 1'b1;
            st_code  <= ST_SHORT;
            st_fill  <= fill;
            state    <= S_IDLE;
          end else begin
            remaining <= len_lo[6:0];
            state     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rptr      <= ptr_inc(rptr);
          fill      <= fill - FW'(1);
          remaining <= remaining - 7'd1;
          rd_pend   <= 1'b1;
          rd_last   <= (remaining == 7'd1);
          rd_fill   <= fill - FW'(1);
          if (remaining == 7'd1) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign st_fill_x    = {8'd0, st_fill};
  assign rd_fill_x    = {8'd0, rd_fill};
  assign strobe       = st_valid | rd_pend;
  assign data_out     = rd_pend ? mem_q : 8'd0;
  assign last         = rd_pend ? rd_last : 1'b1;
  assign status       = rd_pend ? ST_OK : st_code;
  assign stored_count = rd_pend ? rd_fill_x[7:0] : st_fill_x[7:0];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= RING_DEPTH)
    else $error("fill level above ring depth");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(st_valid && rd_pend))
    else $error("status and byte result in the same cycle");

  a_drain_run: assert property (@(posedge clk) disable iff (rst)
    rd_pend && !rd_last |=> rd_pend)
    else $error("gap inside a drained byte run");

  a_drain_cover: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> 32'(fill) >= 32'(remaining) && remaining != 7'd0)
    else $error("drain count exceeds stored bytes");

endmodule

@@ design/byte_ring_buffer_packet_reader.sv @@
`timescale 1ns / 1ps
// write, or read refused without a header look: a single status result
// counted read of n bytes: n byte results, one byte per cycle once the run starts
// packet read: the header bytes read through the one ring read port, then a length check,
// then the bytes one per cycle or a single refusal; writes one per cycle while the back end is idle
// results cannot be held off; busy only reflects the two-entry command queue
// rst (synchronous) empties the ring and the queue; ring contents stay as they were
module byte_ring_buffer_packet_reader #(
  parameter int RING_DEPTH = brb_pkg::RING_DEPTH_DEF,
  parameter int PACKET_MAX = brb_pkg::PACKET_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] data_in,
  input  logic [6:0] read_count,
  output logic       strobe,
  output logic [7:0] data_out,
  output logic       last,
  output logic [1:0] status,
  output logic [7:0] stored_count
);
  import brb_pkg::*;

  // classified item at the queue head, handed to the back end
  brb_entry_t head;
  logic       head_valid;
  logic       pop;

  // front end: takes items, settles count checks that need no state, queues them
  brb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .data_in    (data_in),
    .read_count (read_count),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // back end: owns the ring store, pointers and fill level, and emits every result
  brb_back #(
    .RING_DEPTH (RING_DEPTH),
    .PACKET_MAX (PACKET_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .strobe       (strobe),
    .data_out     (data_out),
    .last         (last),
    .status       (status),
    .stored_count (stored_count)
  );

endmodule

@@ tb/brb_result_checker.sv @@
`timescale 1ns / 1ps
module brb_result_checker
  import brb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int PACKET_MAX = PACKET_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] data_in,
  input  logic [6:0] read_count,
  input  logic       strobe,
  input  logic [7:0] data_out,
  input  logic       last,
  input  logic [1:0] status,
  input  logic [7:0] stored_count,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
    logic [7:0] stored;
  } byte_result_t;

  byte_result_t expected_results[$];
  logic [7:0]   ring_bytes[RING_DEPTH];
  int           rd_ptr;
  int           wr_ptr;
  int           fill;

  function automatic int next_slot(int p);
    return (p + 1 == RING_DEPTH) ? 0 : p + 1;
  endfunction

  task automatic add_result(logic [7:0] d, logic l, logic [1:0] s);
    byte_result_t r;
    r.data   = d;
    r.last   = l;
    r.status = s;
    r.stored = 8'(fill);
    expected_results.push_back(r);
  endtask

  task automatic drain_bytes(int count);
    for (int i = 0; i < count; i++) begin
      logic [7:0] b;
      b      = ring_bytes[rd_ptr];
      rd_ptr = next_slot(rd_ptr);
      fill--;
      add_result(b, i == count - 1, ST_OK);
    end
  endtask

  task automatic predict_item(logic [1:0] c, logic [7:0] d, logic [6:0] n);
    logic [31:0] hdr_len;
    int          p;
    case (c)
      CMD_WRITE: begin
        if (fill >= RING_DEPTH) begin
          add_result(8'h00, 1'b1, ST_FULL);
        end else begin
          ring_bytes[wr_ptr] = d;
          wr_ptr = next_slot(wr_ptr);
          fill++;
          add_result(8'h00, 1'b1, ST_OK);
        end
      end
      CMD_COUNT: begin
        if (n == 0 || n > RESULT_LIMIT || n > fill) add_result(8'h00, 1'b1, ST_SHORT);
        else drain_bytes(int'(n));
      end
      CMD_PACKET: begin
        if (fill < HEADER_BYTES) begin
          add_result(8'h00, 1'b1, ST_SHORT);
        end else begin
          // little-endian length, may wrap around the end of the ring
          hdr_len = '0;
          p = rd_ptr;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            hdr_len |= 32'(ring_bytes[p]) << (8 * i);
            p = next_slot(p);
          end
          if (hdr_len < HEADER_BYTES || hdr_len > PACKET_MAX) add_result(8'h00, 1'b1, ST_BADLEN);
          else if (hdr_len > fill) add_result(8'h00, 1'b1, ST_SHORT);
          else drain_bytes(int'(hdr_len));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    byte_result_t want;
    byte_result_t got;
    got = '{data: data_out, last: last, status: status, stored: stored_count};
    if (expected_results.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result with nothing expected: data_out=%02h last=%0d status=%0d stored=%0d",
                 $time, data_out, last, status, stored_count);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        if (mismatches < 10)
          $display("%0t: expected data_out=%02h last=%0d status=%0d stored=%0d, got %02h %0d %0d %0d",
                   $time, want.data, want.last, want.status, want.stored,
                   data_out, last, status, stored_count);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      rd_ptr     = 0;
      wr_ptr     = 0;
      fill       = 0;
      mismatches = 0;
    end else begin
      // results of this edge always belong to items accepted earlier
      if (strobe) check_result();
      if (start && !busy) predict_item(cmd, data_in, read_count);
    end
    outstanding = expected_results.size();
  end

endmodule

@@ tb/byte_ring_buffer_packet_reader_test.sv @@
`timescale 1ns / 1ps
module byte_ring_buffer_packet_reader_test;
  import brb_pkg::*;

  localparam int         RING_DEPTH   = RING_DEPTH_DEF;
  localparam int         PACKET_MAX   = PACKET_MAX_DEF;
  localparam int         RANDOM_ITEMS = 430;
  localparam int         PHASE_ITEMS  = 110;
  // a 64-byte read behind a full command queue stays well inside this quiet limit
  localparam int         QUIET_LIMIT  = 5000;
  // packet read latency plus margin, for items that produce no result
  localparam int         DRAIN_CYCLES = 24;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] cmd;
  logic [7:0] data_in;
  logic [6:0] read_count;
  logic       strobe;
  logic [7:0] data_out;
  logic       last;
  logic [1:0] status;
  logic [7:0] stored_count;

  int         mismatches;
  int         outstanding;
  int         idle_pct;
  int         items_sent;
  int         quiet_cycles;
  // bytes the stimulus believes are held, used only to steer the sequences
  logic [7:0] held[$];

  always #4 clk = ~clk;

  byte_ring_buffer_packet_reader #(
    .RING_DEPTH(RING_DEPTH),
    .PACKET_MAX(PACKET_MAX)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .data_in      (data_in),
    .read_count   (read_count),
    .strobe       (strobe),
    .data_out     (data_out),
    .last         (last),
    .status       (status),
    .stored_count (stored_count)
  );

  brb_result_checker #(
    .RING_DEPTH(RING_DEPTH),
    .PACKET_MAX(PACKET_MAX)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .data_in      (data_in),
    .read_count   (read_count),
    .strobe       (strobe),
    .data_out     (data_out),
    .last         (last),
    .status       (status),
    .stored_count (stored_count),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // watchdog: any accepted item or result keeps the run alive
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // header value at the head, clamped above the packet limit; 0 if too few bytes
  function automatic int frame_length();
    logic [31:0] len;
    len = '0;
    if (held.size() < HEADER_BYTES) return 0;
    for (int i = 0; i < HEADER_BYTES; i++) len |= 32'(held[i]) << (8 * i);
    return (len > PACKET_MAX) ? PACKET_MAX + 1 : int'(len);
  endfunction

  // head holds a complete packet with a legal length
  function automatic bit head_is_frame();
    int len;
    len = frame_length();
    return len >= HEADER_BYTES && len <= PACKET_MAX && len <= held.size();
  endfunction

  // track what an accepted item does to the held bytes
  task automatic note_accepted(logic [1:0] c, logic [7:0] d, logic [6:0] n);
    case (c)
      CMD_WRITE:  if (held.size() < RING_DEPTH) held.push_back(d);
      CMD_COUNT:  if (n != 0 && n <= RESULT_LIMIT && n <= held.size())
                    repeat (n) void'(held.pop_front());
      CMD_PACKET: if (head_is_frame()) repeat (frame_length()) void'(held.pop_front());
      default: ;
    endcase
  endtask

  // present one item, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_item(logic [1:0] c, logic [7:0] d, logic [6:0] n);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= c;
    data_in    <= d;
    read_count <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    note_accepted(c, d, n);
    if (c != CMD_UNUSED) items_sent++;
  endtask

  // unused fields carry random bits so every input bit toggles
  task automatic write_byte(logic [7:0] d);
    send_item(CMD_WRITE, d, 7'($urandom));
  endtask

  task automatic read_packet();
    send_item(CMD_PACKET, 8'($urandom), 7'($urandom));
  endtask

  task automatic read_bytes(int n);
    send_item(CMD_COUNT, 8'($urandom), 7'(n));
  endtask

  task automatic write_header(int unsigned value);
    for (int i = 0; i < HEADER_BYTES; i++) write_byte(8'(value >> (8 * i)));
  endtask

  task automatic send_frame(int len);
    write_header(len);
    repeat (len - HEADER_BYTES) write_byte(8'($urandom));
  endtask

  // flush bytes until the head starts a legal packet again
  task automatic realign();
    while (held.size() > 0 && !head_is_frame())
      read_bytes((held.size() > RESULT_LIMIT) ? RESULT_LIMIT : held.size());
  endtask

  // drain whole packets, or raw bytes where no packet heads the ring, until a new one of len bytes fits
  task automatic make_room(int len);
    while (held.size() + len > RING_DEPTH) begin
      if (head_is_frame()) read_packet();
      else read_bytes((held.size() > RESULT_LIMIT) ? RESULT_LIMIT : held.size());
    end
  endtask

  initial begin
    int pick;
    int len;
    int lim;
    int phase;
    int phase_end;
    int random_end;
    bit flooded;

    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_WRITE;
    data_in    = '0;
    read_count = '0;
    idle_pct   = 0;
    items_sent = 0;
    flooded    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty ring, zero and oversized counts, one good packet
    read_packet();
    read_bytes(0);
    write_header(5);
    write_byte(8'hff);
    read_bytes(6);
    read_bytes(127);
    read_packet();
    send_item(CMD_UNUSED, 8'hff, 7'h7f);
    // header length below the header size
    write_header(3);
    read_packet();
    read_bytes(HEADER_BYTES);
    // legal length at the packet limit but not all of it stored
    write_header(PACKET_MAX);
    read_packet();

    // random: mostly whole packets written then read, mixed with noise
    random_end = items_sent + RANDOM_ITEMS;
    phase_end  = items_sent;
    phase      = 0;
    while (items_sent < random_end) begin
      if (items_sent >= phase_end) begin
        // idle mix: none, sender 63%, none (results cannot be stalled), sender 38%
        case (phase % 4)
          1:       idle_pct = 63;
          3:       idle_pct = 38;
          default: idle_pct = 0;
        endcase
        phase++;
        phase_end = items_sent + PHASE_ITEMS;
      end
      // one pass to a full ring, then writes that must be refused
      if (!flooded && items_sent >= random_end - 250) begin
        while (held.size() < RING_DEPTH) write_byte(8'($urandom));
        repeat ($urandom_range(1, 3)) write_byte(8'($urandom));
        read_packet();
        flooded = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        // mostly short packets, a few up to the limit
        len = ($urandom_range(9) < 7) ? $urandom_range(HEADER_BYTES, 12)
                                      : $urandom_range(HEADER_BYTES, PACKET_MAX);
        realign();
        make_room(len);
        send_frame(len);
        if ($urandom_range(9) < 6) read_packet();
      end else if (pick < 60) begin
        read_packet();
      end else if (pick < 75) begin
        lim = (held.size() > RESULT_LIMIT) ? RESULT_LIMIT : held.size();
        if (lim > 0 && $urandom_range(9) < 7) read_bytes($urandom_range(1, lim));
        else read_bytes($urandom_range(0, 127));
      end else if (pick < 88) begin
        // stray bytes break packet alignment
        repeat ($urandom_range(1, 6)) write_byte(8'($urandom));
      end else if (pick < 93) begin
        send_item(CMD_UNUSED, 8'($urandom), 7'($urandom));
      end else begin
        realign();
        read_packet();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
